@@ rtl/segx_pkg.sv @@
// Package for the segment intersection block: widths, item structs, result codes.
// No dependencies.
`timescale 1ns / 1ps
package segx_pkg;
  localparam int CW = 16;             // coordinate width
  localparam int DW = CW + 1;         // difference width
  localparam int PW = 2 * DW + 1;     // cross / dot product width
  localparam int QW = CW + 2;         // quotient bits of m*t/d
  localparam int NC = QW;             // divider cells
  localparam int BW = $clog2(QW);     // quotient bit index width

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_POINT   = 2'd1,
    KIND_OVERLAP = 2'd2
  } kind_t;

  typedef struct packed {
    logic signed [CW-1:0] a_x;
    logic signed [CW-1:0] a_y;
    logic signed [CW-1:0] b_x;
    logic signed [CW-1:0] b_y;
    logic signed [CW-1:0] c_x;
    logic signed [CW-1:0] c_y;
    logic signed [CW-1:0] d_x;
    logic signed [CW-1:0] d_y;
  } seg_in_t;

  typedef struct packed {
    logic [1:0]           kind;
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
  } seg_out_t;

  // one axis travelling through the divider chain
  typedef struct packed {
    logic                 neg;
    logic [DW-1:0]        mag;
    logic signed [CW-1:0] base;
    logic [QW-1:0]        q;
    logic [PW:0]          r;
  } axis_t;

  // shared item context in the divider chain
  typedef struct packed {
    logic          vld;
    logic [1:0]    kind;
    logic [PW-1:0] tn;
    logic [PW-1:0] den;
  } ctx_t;
endpackage

@@ rtl/segx_front.sv @@
// Front end: differences, cross products, parameter tests and collinear overlap.
// Depends on segx_pkg. Two register stages.
`timescale 1ns / 1ps
module segx_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             vld_i,
  input  segx_pkg::seg_in_t in_i,
  output segx_pkg::ctx_t    ctx_o,
  output segx_pkg::axis_t   ax_o,
  output segx_pkg::axis_t   ay_o
);
  import segx_pkg::*;

  // stage 1: differences and products
  logic                 s1_vld_r;
  logic signed [CW-1:0] s1_ax_r, s1_ay_r;
  logic signed [DW-1:0] s1_abx_r, s1_aby_r;
  logic signed [PW-1:0] s1_den_r, s1_tn_r, s1_un_r;
  logic signed [PW-1:0] s1_c1_r, s1_c2_r, s1_sb_r, s1_sc_r, s1_sd_r;
  logic                 s1_vz_r, s1_eq_r;

  logic signed [DW-1:0] abx, aby, cdx, cdy, cax, cay, dax, day, vx, vy;
  logic                 abz;

  always_comb begin
    abx = DW'(in_i.b_x) - DW'(in_i.a_x);
    aby = DW'(in_i.b_y) - DW'(in_i.a_y);
    cdx = DW'(in_i.d_x) - DW'(in_i.c_x);
    cdy = DW'(in_i.d_y) - DW'(in_i.c_y);
    cax = DW'(in_i.c_x) - DW'(in_i.a_x);
    cay = DW'(in_i.c_y) - DW'(in_i.a_y);
    dax = DW'(in_i.d_x) - DW'(in_i.a_x);
    day = DW'(in_i.d_y) - DW'(in_i.a_y);
    abz = (abx == '0) && (aby == '0);
    vx  = abz ? cdx : abx;
    vy  = abz ? cdy : aby;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= vld_i;
    end
    s1_ax_r  <= in_i.a_x;
    s1_ay_r  <= in_i.a_y;
    s1_abx_r <= abx;
    s1_aby_r <= aby;
    s1_den_r <= PW'(abx * cdy) - PW'(aby * cdx);
    s1_tn_r  <= PW'(cax * cdy) - PW'(cay * cdx);
    s1_un_r  <= PW'(cax * aby) - PW'(cay * abx);
    s1_c1_r  <= PW'(vx * cay) - PW'(vy * cax);
    s1_c2_r  <= PW'(vx * day) - PW'(vy * dax);
    s1_sb_r  <= PW'(abx * vx) + PW'(aby * vy);
    s1_sc_r  <= PW'(cax * vx) + PW'(cay * vy);
    s1_sd_r  <= PW'(dax * vx) + PW'(day * vy);
    s1_vz_r  <= (vx == '0) && (vy == '0);
    s1_eq_r  <= (cax == '0) && (cay == '0);
  end

  // stage 2: decisions
  logic signed [PW-1:0] den, tn, un, lo1, hi1, lo2, hi2, lo, hi;
  logic [1:0]           kind;

  always_comb begin
    den = s1_den_r[PW-1] ? -s1_den_r : s1_den_r;
    tn  = s1_den_r[PW-1] ? -s1_tn_r : s1_tn_r;
    un  = s1_den_r[PW-1] ? -s1_un_r : s1_un_r;
    lo1 = s1_sb_r[PW-1] ? s1_sb_r : '0;
    hi1 = s1_sb_r[PW-1] ? '0 : s1_sb_r;
    lo2 = (s1_sc_r < s1_sd_r) ? s1_sc_r : s1_sd_r;
    hi2 = (s1_sc_r < s1_sd_r) ? s1_sd_r : s1_sc_r;
    lo  = (lo1 > lo2) ? lo1 : lo2;
    hi  = (hi1 < hi2) ? hi1 : hi2;
    kind = KIND_NONE;
    if (s1_den_r != '0) begin
      if (!tn[PW-1] && tn <= den && !un[PW-1] && un <= den) kind = KIND_POINT;
    end else if (s1_vz_r) begin
      if (s1_eq_r) kind = KIND_OVERLAP;
    end else if (s1_c1_r == '0 && s1_c2_r == '0 && lo <= hi) begin
      kind = KIND_OVERLAP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_o.vld <= 1'b0;
    end else begin
      ctx_o.vld <= s1_vld_r;
    end
    ctx_o.kind <= kind;
    ctx_o.tn   <= tn;
    ctx_o.den  <= (den == '0) ? PW'(1) : den;
    ax_o.neg   <= s1_abx_r[DW-1];
    ax_o.mag   <= s1_abx_r[DW-1] ? DW'(-s1_abx_r) : DW'(s1_abx_r);
    ax_o.base  <= s1_ax_r;
    ax_o.q     <= '0;
    ax_o.r     <= '0;
    ay_o.neg   <= s1_aby_r[DW-1];
    ay_o.mag   <= s1_aby_r[DW-1] ? DW'(-s1_aby_r) : DW'(s1_aby_r);
    ay_o.base  <= s1_ay_r;
    ay_o.q     <= '0;
    ay_o.r     <= '0;
  end
endmodule

@@ rtl/segx_cell.sv @@
// One divider cell: one quotient bit of floor(mag*tn/den) for both axes.
// Depends on segx_pkg. Chained by the top level.
`timescale 1ns / 1ps
module segx_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [segx_pkg::BW-1:0] bit_i,
  input  segx_pkg::ctx_t        ctx_i,
  input  segx_pkg::axis_t       ax_i,
  input  segx_pkg::axis_t       ay_i,
  output segx_pkg::ctx_t        ctx_o,
  output segx_pkg::axis_t       ax_o,
  output segx_pkg::axis_t       ay_o
);
  import segx_pkg::*;

  // r < den and tn <= den, so r*2+tn < 3*den: at most two subtractions
  function automatic axis_t step(axis_t a, ctx_t c, logic [BW-1:0] b);
    logic [PW+1:0] r;
    logic [1:0]    d;
    axis_t         o;
    r = {a.r, 1'b0} + ((b < DW && a.mag[b[$clog2(DW)-1:0]]) ? (PW+2)'(c.tn) : '0);
    d = 2'd0;
    if (r >= (PW+2)'(c.den)) begin
      r = r - (PW+2)'(c.den);
      d = 2'd1;
    end
    if (r >= (PW+2)'(c.den)) begin
      r = r - (PW+2)'(c.den);
      d = 2'd2;
    end
    o   = a;
    o.q = {a.q[QW-2:0], 1'b0} + QW'(d);
    o.r = r[PW:0];
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_o.vld <= 1'b0;
    end else begin
      ctx_o.vld <= ctx_i.vld;
    end
    ctx_o.kind <= ctx_i.kind;
    ctx_o.tn   <= ctx_i.tn;
    ctx_o.den  <= ctx_i.den;
    ax_o       <= step(ax_i, ctx_i, bit_i);
    ay_o       <= step(ay_i, ctx_i, bit_i);
  end
endmodule

@@ rtl/segx_back.sv @@
// Back end: truncation toward zero and result register.
// Depends on segx_pkg.
`timescale 1ns / 1ps
module segx_back (
  input  logic              clk,
  input  logic              rst_n,
  input  segx_pkg::ctx_t    ctx_i,
  input  segx_pkg::axis_t   ax_i,
  input  segx_pkg::axis_t   ay_i,
  output logic              vld_o,
  output segx_pkg::seg_out_t res_o
);
  import segx_pkg::*;

  function automatic logic [CW-1:0] fin(axis_t a);
    logic signed [QW+1:0] base;
    base = a.neg ? QW'(0) + (QW+2)'(signed'(a.base)) - (QW+2)'(a.q)
                 : (QW+2)'(signed'(a.base)) + (QW+2)'(a.q);
    if (a.r != '0 && base != '0) begin
      if (base > 0 && a.neg) base = base - 1'b1;
      else if (base < 0 && !a.neg) base = base + 1'b1;
    end
    return base[CW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else begin
      vld_o <= ctx_i.vld;
    end
    res_o.kind    <= ctx_i.kind;
    res_o.point_x <= (ctx_i.kind == KIND_POINT) ? fin(ax_i) : '0;
    res_o.point_y <= (ctx_i.kind == KIND_POINT) ? fin(ay_i) : '0;
  end
endmodule

@@ rtl/segment_intersection.sv @@
// Top level of the segment intersection block: front end, divider cell chain, back end.
// Depends on segx_pkg, segx_front, segx_cell, segx_back.
//
// Usage:
//   Drive in_item with two segments AB and CD and raise start; the item is
//   taken at each rising edge with start high and busy low. busy is always
//   low, so a new item may enter every cycle.
//   Each item gives one result: out_item (kind, point_x, point_y) is shown
//   for exactly one cycle with out_valid high.
//   From acceptance to out_valid an item passes two front stages, 18 divider
//   cells and one output register. Throughput one item per cycle; the chain
//   of 18 single-bit divider cells sets the latency.
//   The receiver cannot stall; results are presented and must be taken.
//   Synchronous active-low reset clears all valid flags; items in flight
//   are dropped.
`timescale 1ns / 1ps
module segment_intersection (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  segx_pkg::seg_in_t  in_item,
  output logic               out_valid,
  output segx_pkg::seg_out_t out_item
);
  import segx_pkg::*;

  ctx_t  ctx [NC+1];
  axis_t axx [NC+1];
  axis_t axy [NC+1];

  assign busy = 1'b0;

  segx_front u_front (
    .clk, .rst_n, .vld_i(start), .in_i(in_item),
    .ctx_o(ctx[0]), .ax_o(axx[0]), .ay_o(axy[0])
  );

  for (genvar g = 0; g < NC; g++) begin : g_cell
    segx_cell u_cell (
      .clk, .rst_n,
      .bit_i(BW'(QW - 1 - g)),
      .ctx_i(ctx[g]), .ax_i(axx[g]), .ay_i(axy[g]),
      .ctx_o(ctx[g+1]), .ax_o(axx[g+1]), .ay_o(axy[g+1])
    );
  end

  segx_back u_back (
    .clk, .rst_n, .ctx_i(ctx[NC]), .ax_i(axx[NC]), .ay_i(axy[NC]),
    .vld_o(out_valid), .res_o(out_item)
  );
endmodule

@@ rtl/segx_check.sv @@
// Port-level checker for segment_intersection, bound to the top level.
// Depends on segx_pkg.
`timescale 1ns / 1ps
module segx_check (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input segx_pkg::seg_out_t out_item
);
  import segx_pkg::*;

  a_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.kind == KIND_NONE || out_item.kind == KIND_POINT ||
                   out_item.kind == KIND_OVERLAP))
    else $error("bad kind");
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.kind != KIND_POINT) |->
      (out_item.point_x == '0 && out_item.point_y == '0))
    else $error("point not zero");
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 21))
    else $error("result without item");
endmodule

bind segment_intersection segx_check u_check (
  .clk, .rst_n, .start, .busy, .out_valid, .out_item
);

@@ verif/segment_intersection_checker.sv @@
// Checker for the segment intersection block: predicts each result from the accepted item
// and compares it with the block's output. Depends on segx_pkg.
`timescale 1ns / 1ps
module segment_intersection_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  segx_pkg::seg_in_t  in_item,
  input  logic               out_valid,
  input  segx_pkg::seg_out_t out_item,
  output int                 fail_count,
  output int                 pending
);
  import segx_pkg::*;

  seg_out_t crossing_q[$];

  initial fail_count = 0;
  assign pending = crossing_q.size();

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  // trunc toward zero of a + ab*tn/den, exact in wide signed arithmetic
  function automatic logic signed [CW-1:0] interp(input longint a, input longint ab,
                                                  input longint tn, input longint den);
    longint num;
    longint q;
    num = a * den + ab * tn;
    q = num / den;
    return CW'(q);
  endfunction

  function automatic seg_out_t crossing_of(input seg_in_t s);
    seg_out_t r;
    longint ax, ay, abx, aby, cdx, cdy, cax, cay, dax, day, den, tn, un;
    longint vx, vy, sb, sc, sd, lo, hi;
    ax = s.a_x; ay = s.a_y;
    abx = longint'(s.b_x) - ax; aby = longint'(s.b_y) - ay;
    cdx = longint'(s.d_x) - s.c_x; cdy = longint'(s.d_y) - s.c_y;
    cax = longint'(s.c_x) - ax; cay = longint'(s.c_y) - ay;
    dax = longint'(s.d_x) - ax; day = longint'(s.d_y) - ay;
    r = '0;
    den = abx * cdy - aby * cdx;
    if (den != 0) begin
      tn = cax * cdy - cay * cdx;
      un = cax * aby - cay * abx;
      if (den < 0) begin
        den = -den; tn = -tn; un = -un;
      end
      if (tn >= 0 && tn <= den && un >= 0 && un <= den) begin
        r.kind = KIND_POINT;
        r.point_x = interp(ax, abx, tn, den);
        r.point_y = interp(ay, aby, tn, den);
      end
    end else begin
      vx = abx; vy = aby;
      if (vx == 0 && vy == 0) begin
        vx = cdx; vy = cdy;
      end
      if (vx == 0 && vy == 0) begin
        if (cax == 0 && cay == 0) r.kind = KIND_OVERLAP;
      end else if (vx * cay - vy * cax == 0 && vx * day - vy * dax == 0) begin
        sb = abx * vx + aby * vy;
        sc = cax * vx + cay * vy;
        sd = dax * vx + day * vy;
        lo = (sc < sd) ? sc : sd;
        hi = (sc < sd) ? sd : sc;
        if (sb < 0) begin
          if (lo < sb) lo = sb;
          if (hi > 0) hi = 0;
        end else begin
          if (lo < 0) lo = 0;
          if (hi > sb) hi = sb;
        end
        if (lo <= hi) r.kind = KIND_OVERLAP;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    seg_out_t exp_r;
    if (rst_n) begin
      if (start && !busy) crossing_q = {crossing_q, crossing_of(in_item)};
      if (out_valid) begin
        if (crossing_q.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          exp_r = crossing_q.pop_front();
          if (out_item.kind !== exp_r.kind)
            report_mismatch($sformatf("kind %0d expected %0d", out_item.kind, exp_r.kind));
          if (out_item.point_x !== exp_r.point_x)
            report_mismatch($sformatf("point_x %0d expected %0d",
                                      out_item.point_x, exp_r.point_x));
          if (out_item.point_y !== exp_r.point_y)
            report_mismatch($sformatf("point_y %0d expected %0d",
                                      out_item.point_y, exp_r.point_y));
        end
      end
    end
  end
endmodule

@@ verif/segment_intersection_test.sv @@
// Testbench top for the segment intersection block: drives directed and random segment pairs
// and gives the verdict. Depends on segx_pkg, segment_intersection, segment_intersection_checker.
`timescale 1ns / 1ps
module segment_intersection_test;
  import segx_pkg::*;

  localparam int LATENCY = 21;
  localparam int N_RANDOM = 1000;
  localparam int CYCLE_LIMIT = 200000;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  seg_in_t in_item;
  logic out_valid;
  seg_out_t out_item;
  int fail_count;
  int pending;
  int cycles;

  segment_intersection dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  segment_intersection_checker checker_i (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("segment_intersection_test: FAIL");
        $finish;
      end
    end
  end

  function automatic logic signed [CW-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      1: return CW'($urandom_range(0, 64)) - 16'sd32;
      2: return CW'($urandom_range(0, 4096)) - 16'sd2048;
      default: return CW'($urandom);
    endcase
  endfunction

  function automatic seg_in_t make_pair(input int c0, c1, c2, c3, c4, c5, c6, c7);
    seg_in_t s;
    s.a_x = CW'(c0); s.a_y = CW'(c1); s.b_x = CW'(c2); s.b_y = CW'(c3);
    s.c_x = CW'(c4); s.c_y = CW'(c5); s.d_x = CW'(c6); s.d_y = CW'(c7);
    return s;
  endfunction

  // mostly crossing, collinear or shared-endpoint shapes with random content, the rest pure noise
  function automatic seg_in_t random_pair();
    seg_in_t s;
    int k, dx, dy;
    s = {rand_coord(), rand_coord(), rand_coord(), rand_coord(),
         rand_coord(), rand_coord(), rand_coord(), rand_coord()};
    case ($urandom_range(0, 5))
      0: begin // C near AB's midpoint and at or below it, D above C
        s.c_x = (s.a_x >>> 1) + (s.b_x >>> 1) + CW'($urandom_range(0, 200)) - 16'sd100;
        s.c_y = (s.a_y >>> 1) + (s.b_y >>> 1) - CW'($urandom_range(0, 2000));
        s.d_x = s.c_x + CW'($urandom_range(0, 200)) - 16'sd100;
        s.d_y = s.c_y + CW'($urandom_range(1, 4000));
      end
      1, 2: begin // collinear along a small step, D sometimes moved off the line
        dx = $urandom_range(0, 20) - 10; dy = $urandom_range(0, 20) - 10;
        s.a_x = CW'($urandom_range(0, 2000)) - 16'sd1000;
        s.a_y = CW'($urandom_range(0, 2000)) - 16'sd1000;
        k = $urandom_range(0, 40); s.b_x = s.a_x + CW'(k*dx); s.b_y = s.a_y + CW'(k*dy);
        k = $urandom_range(0, 80) - 20; s.c_x = s.a_x + CW'(k*dx); s.c_y = s.a_y + CW'(k*dy);
        k = $urandom_range(0, 80) - 20; s.d_x = s.a_x + CW'(k*dx); s.d_y = s.a_y + CW'(k*dy);
        if ($urandom_range(0, 3) == 0) s.d_y = s.d_y + 16'sd1;
      end
      3: begin // shared endpoint
        s.c_x = $urandom_range(0, 1) ? s.a_x : s.b_x;
        s.c_y = (s.c_x == s.a_x) ? s.a_y : s.b_y;
      end
      default: ;
    endcase
    return s;
  endfunction

  task automatic send(input seg_in_t s);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
    repeat (gap) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_item <= s;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  initial begin
    seg_in_t dir[$];
    int n;
    start = 1'b0;
    in_item = '0;
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    dir = {dir, make_pair(0, 0, 160, 160, 0, 160, 160, 0)};          // plain cross
    dir = {dir, make_pair(0, 0, 160, 0, 160, 0, 160, 80)};           // endpoint touch
    dir = {dir, make_pair(0, 0, 160, 0, 80, 0, 80, 80)};             // T at t inside
    dir = {dir, make_pair(0, 0, 160, 0, 0, 16, 160, 16)};            // parallel miss
    dir = {dir, make_pair(0, 0, 160, 0, 80, 0, 320, 0)};             // collinear overlap
    dir = {dir, make_pair(0, 0, 160, 0, 160, 0, 320, 0)};            // collinear touch
    dir = {dir, make_pair(0, 0, 160, 0, 161, 0, 320, 0)};            // collinear gap
    dir = {dir, make_pair(32, 0, 32, 0, 0, 0, 64, 0)};               // point on CD
    dir = {dir, make_pair(32, 1, 32, 1, 0, 0, 64, 0)};               // point off CD
    dir = {dir, make_pair(5, 5, 5, 5, 5, 5, 5, 5)};                  // both points, equal
    dir = {dir, make_pair(5, 5, 5, 5, 5, 6, 5, 6)};                  // both points, apart
    dir = {dir, make_pair(0, 0, 3, 7, 0, 5, 3, 0)};                  // rounding, positive
    dir = {dir, make_pair(0, 0, -3, -7, 0, -5, -3, 0)};              // rounding, negative
    dir = {dir, make_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768)};
    dir = {dir, make_pair(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767)};
    dir = {dir, make_pair(-32768, 0, 32767, 0, -32768, 0, 32767, 0)};
    dir = {dir, make_pair(-32768, -32768, -32768, -32768, -32768, -32768, 32767, 32767)};
    dir = {dir, make_pair(-1, -1, -1, -1, -1, -1, -1, -1)};
    dir = {dir, make_pair(0, 0, 160, 160, 200, 0, 300, 10)};         // lines meet outside
    foreach (dir[i]) send(dir[i]);
    for (n = 0; n < N_RANDOM; n++) send(random_pair());
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    if (fail_count == 0) begin
      $display("segment_intersection_test: PASS");
    end else begin
      $display("segment_intersection_test: FAIL");
    end
    $finish;
  end
endmodule
